>>> design/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define STLS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Same-cycle implication.
`define STLS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define STLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/stls_pkg.sv
// Package: default sizes, request and result types, command codes and character constants of the scrollback block.
package stls_pkg;

    localparam int LINE_COLUMNS_DEF = 40;
    localparam int VIEW_ROWS_DEF    = 32;
    localparam int RING_LINES_DEF   = 64;

    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_FLUSH = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_NONE  = 8'h00;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  rx_byte;
        logic [4:0]  view_row;
        logic [5:0]  view_col;
    } t_in_req;

    typedef struct packed {
        logic [7:0]  char_out;
        logic        line_committed;
        logic [6:0]  lines_stored;
        logic [5:0]  rows_visible;
        logic [5:0]  pending_length;
        logic [31:0] bytes_received;
    } t_out_req;

endpackage

>>> design/stls_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/serial_text_line_scrollback_top.sv
// Top level: serial text line assembly into a scrollback ring with character readout.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------
//   in      | request   | i_in_valid / o_in_stall   | i_in_data  (t_in_req)
//   out     | result    | o_out_valid / i_out_stall | o_out_data (t_out_req)
//
// Byte, clear and empty flush requests finish in the idle state; a request that commits
// a line reads the line map, then writes it back in ST_COMMIT; a visible read goes through
// line map read, text read and result (ST_READ1, ST_READ2). The registered line map read sets this.
// After reset a pass over all RING_LINES slots loads the line map; no request is taken then.
// One result register sits on the output; a result that waits there stalls the next request.
`include "assert_macros.svh"

module serial_text_line_scrollback_top
    import stls_pkg::*;
#(
    parameter int LINE_COLUMNS = LINE_COLUMNS_DEF,
    parameter int VIEW_ROWS    = VIEW_ROWS_DEF,
    parameter int RING_LINES   = RING_LINES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_data
);

    // Widths: line length/count, ring index, fill, physical text row.
    localparam int CW         = $clog2(LINE_COLUMNS + 1);
    localparam int HW         = $clog2(RING_LINES);
    localparam int FW         = $clog2(RING_LINES + 1);
    localparam int PW         = $clog2(RING_LINES + 1);
    localparam int PHYS_ROWS  = RING_LINES + 1;
    localparam int TEXT_DEPTH = PHYS_ROWS * LINE_COLUMNS;
    localparam int TAW        = $clog2(TEXT_DEPTH);
    localparam int VW0        = $clog2(VIEW_ROWS + 1);
    localparam int VCW        = (VW0 > FW) ? VW0 : FW;
    localparam int RCW        = (FW > 5) ? FW : 5;
    localparam int CMPW       = (CW > 6) ? CW : 6;
    localparam int SUMW       = $clog2(2 * RING_LINES + 32) + 1;

    // The line map holds, for each ring slot, the physical text row and length.
    // The text memory has one spare row, where the pending line is built; a
    // commit swaps the spare row with the row of the slot being overwritten,
    // so no character copy is ever needed.
    typedef struct packed {
        logic [PW-1:0] phys;
        logic [CW-1:0] len;
    } t_map_ent;

    localparam int MAP_W = $bits(t_map_ent);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_COMMIT,
        ST_READ1,
        ST_READ2
    } t_state;

    t_state        r_state;
    logic [HW-1:0] r_init;
    logic [HW-1:0] r_head;
    logic [FW-1:0] r_fill;
    logic [CW-1:0] r_pend;
    logic [31:0]   r_total;
    logic [PW-1:0] r_spare;
    logic          r_out_valid;
    t_out_req      r_out;
    t_out_req      r_hold;
    logic [HW-1:0] r_commit_slot;
    logic [CW-1:0] r_commit_len;
    logic [5:0]    r_col;
    logic          r_hit;

    logic [HW-1:0] n_head;
    logic [FW-1:0] n_fill;
    logic [CW-1:0] n_pend;
    logic [31:0]   n_total;

    logic          in_acc;
    logic          out_free;
    logic          out_load;
    logic          commit;
    logic [CW-1:0] commit_len;
    logic          needs_read;
    logic          row_ok;
    logic [FW-1:0] vis_cur;
    logic [FW-1:0] vis_new;
    logic [SUMW-1:0] slot_sum;
    logic [HW-1:0] read_slot;
    logic [7:0]    rx_char;
    t_out_req      res;
    t_out_req      read_res;

    logic           map_we;
    logic [HW-1:0]  map_waddr;
    t_map_ent       map_wdata;
    logic           map_re;
    logic [HW-1:0]  map_raddr;
    logic [MAP_W-1:0] map_rbits;
    t_map_ent       map_rdata;

    logic           txt_we;
    logic [TAW-1:0] txt_waddr;
    logic           txt_re;
    logic [TAW-1:0] txt_raddr;
    logic [7:0]     txt_rdata;
    logic           col_hit;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Result register loads when an accepted request needs no read, or at the end of a read.
    assign out_load = (in_acc && !needs_read) || ((r_state == ST_READ2) && out_free);

    // Visible window: lesser of fill and window height.
    assign vis_cur = (VCW'(r_fill) < VCW'(VIEW_ROWS)) ? r_fill : FW'(VIEW_ROWS);
    assign vis_new = (VCW'(n_fill) < VCW'(VIEW_ROWS)) ? n_fill : FW'(VIEW_ROWS);

    assign row_ok = RCW'(i_in_data.view_row) < RCW'(vis_cur);

    // Ring slot of a visible row: head - visible + row, modulo the ring.
    assign slot_sum  = SUMW'(r_head) + SUMW'(i_in_data.view_row)
                     + SUMW'(RING_LINES) - SUMW'(vis_cur);
    assign read_slot = (slot_sum >= SUMW'(RING_LINES))
                     ? HW'(slot_sum - SUMW'(RING_LINES)) : HW'(slot_sum);

    assign rx_char = ((i_in_data.rx_byte >= CH_SPACE) && (i_in_data.rx_byte <= CH_TILDE))
                   ? i_in_data.rx_byte : CH_DOT;

    // Request decode and next counter values.
    always_comb begin
        n_head     = r_head;
        n_fill     = r_fill;
        n_pend     = r_pend;
        n_total    = r_total;
        commit     = 1'b0;
        commit_len = r_pend;
        txt_we     = 1'b0;
        needs_read = 1'b0;
        unique case (i_in_data.cmd)
            CMD_BYTE: begin
                n_total = r_total + 32'd1;
                if (i_in_data.rx_byte == CH_LF) begin
                    commit = (r_pend != '0);
                end else if (i_in_data.rx_byte != CH_CR) begin
                    txt_we = in_acc;
                    if (r_pend == CW'(LINE_COLUMNS - 1)) begin
                        commit     = 1'b1;
                        commit_len = CW'(LINE_COLUMNS);
                    end else begin
                        n_pend = r_pend + CW'(1);
                    end
                end
            end
            CMD_FLUSH: begin
                commit = (r_pend != '0);
            end
            CMD_CLEAR: begin
                n_head  = '0;
                n_fill  = '0;
                n_pend  = '0;
                n_total = '0;
            end
            CMD_READ: begin
                needs_read = row_ok;
            end
            default: begin
            end
        endcase
        if (commit) begin
            n_pend = '0;
            n_head = (r_head == HW'(RING_LINES - 1)) ? '0 : r_head + HW'(1);
            if (r_fill != FW'(RING_LINES)) begin
                n_fill = r_fill + FW'(1);
            end
        end
        res.char_out       = CH_NONE;
        res.line_committed = commit;
        res.lines_stored   = 7'(n_fill);
        res.rows_visible   = 6'(vis_new);
        res.pending_length = 6'(n_pend);
        res.bytes_received = n_total;
    end

    // Read result: held counters with the character filled in.
    always_comb begin
        read_res          = r_hold;
        read_res.char_out = r_hit ? txt_rdata : CH_SPACE;
    end

    // Pending character goes straight into the spare text row.
    assign txt_waddr = TAW'(r_spare) * TAW'(LINE_COLUMNS) + TAW'(r_pend);

    // Line map read: old row of the slot being overwritten, or a visible row.
    assign map_re    = in_acc && (commit || needs_read);
    assign map_raddr = commit ? r_head : read_slot;
    assign map_rdata = t_map_ent'(map_rbits);

    // Line map write: load pass after reset, or commit write-back.
    always_comb begin
        map_we    = 1'b0;
        map_waddr = r_commit_slot;
        map_wdata = '{phys: r_spare, len: r_commit_len};
        if (r_state == ST_INIT) begin
            map_we    = 1'b1;
            map_waddr = r_init;
            map_wdata = '{phys: PW'(r_init), len: '0};
        end else if (r_state == ST_COMMIT) begin
            map_we = 1'b1;
        end
    end

    // Text read for a visible character; past the line end reads as a space.
    assign col_hit   = CMPW'(r_col) < CMPW'(map_rdata.len);
    assign txt_re    = (r_state == ST_READ1) && col_hit;
    assign txt_raddr = TAW'(map_rdata.phys) * TAW'(LINE_COLUMNS) + TAW'(r_col);

    stls_ram #(
        .WIDTH (MAP_W),
        .DEPTH (RING_LINES)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rbits)
    );

    stls_ram #(
        .WIDTH (8),
        .DEPTH (TEXT_DEPTH)
    ) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (txt_we),
        .i_waddr (txt_waddr),
        .i_wdata (rx_char),
        .i_re    (txt_re),
        .i_raddr (txt_raddr),
        .o_rdata (txt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_init      <= '0;
            r_head      <= '0;
            r_fill      <= '0;
            r_pend      <= '0;
            r_total     <= '0;
            r_spare     <= PW'(RING_LINES);
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_INIT: begin
                    r_init <= r_init + HW'(1);
                    if (r_init == HW'(RING_LINES - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        r_head        <= n_head;
                        r_fill        <= n_fill;
                        r_pend        <= n_pend;
                        r_total       <= n_total;
                        r_commit_slot <= r_head;
                        r_commit_len  <= commit_len;
                        r_col         <= i_in_data.view_col;
                        r_hold        <= res;
                        if (needs_read) begin
                            r_state <= ST_READ1;
                        end else begin
                            r_out   <= res;
                            r_state <= commit ? ST_COMMIT : ST_IDLE;
                        end
                    end
                end
                ST_COMMIT: begin
                    // Overwritten row becomes the new spare.
                    r_spare <= map_rdata.phys;
                    r_state <= ST_IDLE;
                end
                ST_READ1: begin
                    r_hit   <= col_hit;
                    r_state <= ST_READ2;
                end
                ST_READ2: begin
                    if (out_free) begin
                        r_out   <= read_res;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `STLS_ASSERT_ALWAYS(a_pend_below_cols, r_pend < CW'(LINE_COLUMNS), "pending count reached line width")
    `STLS_ASSERT_NEXT(a_commit_writeback, in_acc && commit, r_state == ST_COMMIT, "commit without map write-back")
    `STLS_ASSERT_IMPL(a_spare_unique, r_state == ST_COMMIT, map_rdata.phys != r_spare, "spare row aliases a ring line")
    `STLS_ASSERT_IMPL(a_commit_fill, o_out_valid && o_out_data.line_committed, o_out_data.lines_stored != 7'd0, "commit reported with empty ring")

endmodule
